// File: sv/lds_pkg.sv
// Package for the direction sampler: constants, codes, state and control types, and the CORDIC arctangent table.
`default_nettype none
package lds_pkg;

  localparam int FRAC_BITS_DEF    = 30;
  localparam int CORDIC_STEPS_DEF = 30;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [2:0] ACT_SPHERE  = 3'd1;
  localparam logic [2:0] ACT_HEMI    = 3'd2;
  localparam logic [2:0] ACT_COSHEMI = 3'd3;
  localparam logic [2:0] ACT_CAP     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAW1, ST_DRAW2, ST_ZETA, ST_RAD,
    ST_SQRT, ST_ROOT1, ST_SQRT2, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic draw;
    logic save_w1;
    logic angle;
    logic zeta;
    logic rad;
    logic root1;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic act_dir;
    logic act_cos;
    logic sqrt_busy;
    logic cordic_busy;
    logic out_free;
  } stat_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      5'd30: v = 34'sh00000001;
      default: v = 34'sh0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/lds_ctrl.sv
// Controller state machine for the direction sampler.
`default_nettype none
module lds_ctrl import lds_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DRAW1;
      ST_DRAW1: state_next = stat.act_dir ? ST_DRAW2 : ST_EMIT;
      ST_DRAW2: state_next = ST_ZETA;
      ST_ZETA:  state_next = ST_RAD;
      ST_RAD:   state_next = ST_SQRT;
      ST_SQRT: begin
        if (!stat.sqrt_busy) begin
          if (stat.act_cos)          state_next = ST_ROOT1;
          else if (!stat.cordic_busy) state_next = ST_MUL;
        end
      end
      ST_ROOT1: state_next = ST_SQRT2;
      ST_SQRT2: if (!stat.sqrt_busy && !stat.cordic_busy) state_next = ST_MUL;
      ST_MUL:   state_next = ST_EMIT;
      ST_EMIT:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_DRAW1: begin
        cmd.draw    = 1'b1;
        cmd.save_w1 = 1'b1;
      end
      ST_DRAW2: begin
        cmd.draw  = 1'b1;
        cmd.angle = 1'b1;
      end
      ST_ZETA:  cmd.zeta  = 1'b1;
      ST_RAD:   cmd.rad   = 1'b1;
      ST_ROOT1: cmd.root1 = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_EMIT:  cmd.emit  = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/lds_datapath.sv
// Datapath: generator, polar terms, iterative square root, CORDIC and output register.
`default_nettype none
module lds_datapath import lds_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic [2:0]   in_action,
  input  wire logic [31:0]  in_cap_cos,
  input  wire cmd_t         cmd,
  output stat_t             stat,
  input  wire logic         out_ready,
  output logic              out_valid,
  output logic [127:0]      out_data
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [31:0] LIM = 32'sd1 <<< FRAC_BITS;

  logic [31:0] lcg, lcg_next, w1, capc;
  logic [2:0]  act;
  logic [1:0]  quad;
  logic [29:0] u;

  assign lcg_next = 32'(lcg * LCG_MUL + LCG_ADD);
  assign u = lcg[31:2];

  always_ff @(posedge clk) begin
    if (rst)          lcg <= '0;
    else if (cfg_wen) lcg <= cfg_wdata;
    else if (cmd.draw) lcg <= lcg_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act  <= in_action;
      capc <= in_cap_cos;
    end
    if (cmd.save_w1) w1 <= lcg_next;
  end

  logic is_dir, is_cos, is_hemi, is_cap;
  assign is_dir  = (act == ACT_SPHERE) || (act == ACT_HEMI) ||
                   (act == ACT_COSHEMI) || (act == ACT_CAP);
  assign is_cos  = (act == ACT_COSHEMI);
  assign is_hemi = (act == ACT_HEMI);
  assign is_cap  = (act == ACT_CAP);

  // azimuth angle from the low 30 bits of the first word
  logic signed [33:0] zang;
  logic [60:0] ang_prod;
  assign ang_prod = w1[29:0] * HALF_PI_Q30;
  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      zang <= signed'({3'b000, ang_prod[60:30]});
      quad <= w1[31:30];
    end
  end

  // polar parameter zeta
  logic signed [31:0] cc_cl;
  logic signed [32:0] cc_sc, omc;
  logic [61:0] zprod;
  logic [31:0] zeta;
  always_comb begin
    cc_cl = signed'(capc);
    if (cc_cl > LIM)  cc_cl = LIM;
    if (cc_cl < -LIM) cc_cl = -LIM;
    cc_sc = 33'(cc_cl) <<< SH;
    omc   = 33'sd1073741824 - cc_sc;
    zprod = omc[31:0] * u;
  end
  always_ff @(posedge clk) begin
    if (cmd.zeta) zeta <= is_cap ? zprod[61:30] : {1'b0, u, 1'b0};
  end

  // radicand and polar cosine
  logic [61:0] rad, rad2;
  logic [63:0] sph_prod;
  logic [59:0] usq;
  logic [30:0] one_m_u;
  logic signed [32:0] cz;
  assign sph_prod = (32'h8000_0000 - zeta) * zeta;
  assign usq      = u * u;
  assign one_m_u  = 31'h4000_0000 - {1'b0, u};
  assign rad2     = {1'b0, one_m_u, 30'b0};
  always_comb begin
    if (is_hemi)     rad = 62'h1000_0000_0000_0000 - {2'b00, usq};
    else if (is_cos) rad = {2'b00, u, 30'b0};
    else             rad = sph_prod[61:0];
  end

  // digit-by-digit square root, two radicand bits a cycle
  logic [61:0] sq_op;
  logic [31:0] sq_rem;
  logic [33:0] rem_sh, trial;
  logic [30:0] root;
  logic [4:0]  sq_cnt;
  logic        sq_busy;
  assign rem_sh = {sq_rem, sq_op[61:60]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.rad || cmd.root1) begin
      sq_busy <= 1'b1;
    end else if (sq_busy && sq_cnt == 5'd30) begin
      sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rad || cmd.root1) begin
      sq_op  <= cmd.root1 ? rad2 : rad;
      sq_rem <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end else if (sq_busy) begin
      if (rem_sh >= trial) begin
        sq_rem <= 32'(rem_sh - trial);
        root   <= {root[29:0], 1'b1};
      end else begin
        sq_rem <= rem_sh[31:0];
        root   <= {root[29:0], 1'b0};
      end
      sq_op  <= {sq_op[59:0], 2'b00};
      sq_cnt <= sq_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rad) begin
      if (is_hemi) cz <= signed'({3'b000, u});
      else         cz <= 33'sd1073741824 - signed'({1'b0, zeta});
    end else if (cmd.root1) begin
      cz <= signed'({2'b00, root});
    end
  end

  // CORDIC rotation, one micro-rotation a cycle
  logic signed [33:0] cx, cy, ca, dx, dy, atn;
  logic [CW-1:0] ci;
  logic          c_busy;
  assign dx  = cy >>> ci;
  assign dy  = cx >>> ci;
  assign atn = atan_entry(ci[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_busy <= 1'b0;
    end else if (cmd.zeta) begin
      c_busy <= 1'b1;
    end else if (c_busy && ci == CW'(CORDIC_STEPS - 1)) begin
      c_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zeta) begin
      cx <= CORDIC_GAIN_Q30;
      cy <= '0;
      ca <= zang;
      ci <= '0;
    end else if (c_busy) begin
      if (!ca[33]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        ca <= ca - atn;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        ca <= ca + atn;
      end
      ci <= ci + CW'(1);
    end
  end

  // quadrant fold and scale by the polar sine
  logic signed [33:0] cp, sp;
  logic signed [65:0] px, py;
  always_comb begin
    case (quad)
      2'd0:    begin cp = cx;  sp = cy;  end
      2'd1:    begin cp = -cy; sp = cx;  end
      2'd2:    begin cp = -cx; sp = -cy; end
      default: begin cp = cy;  sp = -cx; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      px <= cp * signed'({1'b0, root});
      py <= sp * signed'({1'b0, root});
    end
  end

  function automatic logic [31:0] emit_val(input logic signed [65:0] v);
    logic signed [65:0] c;
    c = v;
    if (c > 66'sd1073741824)  c = 66'sd1073741824;
    if (c < -66'sd1073741824) c = -66'sd1073741824;
    c = c >>> SH;
    return c[31:0];
  endfunction

  logic [31:0] ox, oy, oz;
  assign ox = emit_val(px >>> 30);
  assign oy = emit_val(py >>> 30);
  assign oz = emit_val(66'(cz));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (is_dir) out_data <= {lcg, oz, oy, ox};
      else        out_data <= {lcg, 96'b0};
    end
  end

  assign stat.act_dir     = is_dir;
  assign stat.act_cos     = is_cos;
  assign stat.sqrt_busy   = sq_busy;
  assign stat.cordic_busy = c_busy;
  assign stat.out_free    = !out_valid || out_ready;

endmodule
`default_nettype wire

// File: sv/lcg_direction_sampler.sv
// Random unit direction sampler driven by a 32-bit linear congruential generator.
//
// Input stream s_axis: one item per request; tdata carries action (mode code)
// and cap_cos (signed cap cosine, FRAC_BITS fraction bits; Q2.30 by default).
// Output stream m_axis: one item per request with dir_x, dir_y, dir_z (Q fixed
// point, FRAC_BITS fraction bits) and the last generator word drawn.
// The seed port loads the generator whenever cfg_wen is high; write it only
// while no item is in flight.
// Uniform mode draws one generator word and goes straight to the output. Direction
// modes are paced by the 31-step square-root unit (the CORDIC runs beside it);
// cosine hemisphere needs two roots back to back.
// One item is in work at a time; s_axis_tready is high only between items.
// A finished item sits in the output register, so the next item is accepted
// and worked on while the receiver stalls; it waits only to be written out.
// Reset (rst, synchronous) clears the generator to zero, empties the output
// register and returns the controller to idle.
`default_nettype none
module lcg_direction_sampler import lds_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [31:0]  cfg_wdata,      // seed
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,   // action[2:0], cap_cos[34:3], zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata    // dir_x, dir_y, dir_z, uniform_word
);

  cmd_t  cmd;
  stat_t stat;

  lds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lds_datapath #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_action  (s_axis_tdata[2:0]),
    .in_cap_cos (s_axis_tdata[34:3]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata)
  );

  localparam logic signed [31:0] ONE_OUT = 32'sd1 <<< FRAC_BITS;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while one is in work");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (signed'(m_axis_tdata[95:64]) <= ONE_OUT) &&
                      (signed'(m_axis_tdata[95:64]) >= -ONE_OUT))
    else $error("dir_z outside unit range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("output register overwritten");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the LCG direction sampler: directed table, then random phases.
`default_nettype none
module tb_top;
  import lds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_ONE = 64'sd1 << 30;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ATAN_TAB [0:31] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000};
  localparam logic [2:0] ACT_UNIFORM = 3'd0;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } sample_t;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] cap;
    bit          typed;
    sample_t     val;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  sample_t     sample_q[$];
  logic [31:0] gen_state;
  int          tx_idle;
  int          rx_idle;
  int          rx_hold;
  int          mismatches;
  longint      cycles;

  lcg_direction_sampler DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] next_word();
    gen_state = LCG_MUL * gen_state + LCG_ADD;
    return gen_state;
  endfunction

  function automatic longint floor_root(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [31:0] clamp_q(longint v);
    if (v > Q_ONE) v = Q_ONE;
    if (v < -Q_ONE) v = -Q_ONE;
    return v[31:0];
  endfunction

  function automatic sample_t predict_sample(logic [2:0] act, logic [31:0] cap);
    sample_t r;
    logic [31:0] w1, w2;
    longint u, cz, sz, zeta, cc, cx, cy, ang, dx, dy, cph, sph;
    w1 = next_word();
    if (act < ACT_SPHERE || act > ACT_CAP) begin
      r = '0;
      r.word = w1;
      return r;
    end
    w2 = next_word();
    u = longint'(w2 >> 2);
    if (act == ACT_HEMI) begin
      cz = u;
      sz = floor_root(Q_ONE * Q_ONE - u * u);
    end else if (act == ACT_COSHEMI) begin
      cz = floor_root(u << 30);
      sz = floor_root((Q_ONE - u) << 30);
    end else begin
      if (act == ACT_SPHERE) begin
        zeta = 2 * u;
      end else begin
        cc = longint'($signed(cap));
        if (cc > Q_ONE) cc = Q_ONE;
        if (cc < -Q_ONE) cc = -Q_ONE;
        zeta = ((Q_ONE - cc) * u) >>> 30;
      end
      cz = Q_ONE - zeta;
      sz = floor_root((2 * Q_ONE - zeta) * zeta);
    end
    // rotate the gain vector by the in-quadrant angle
    ang = (longint'(w1[29:0]) * longint'(HALF_PI_Q30)) >>> 30;
    cx = longint'(CORDIC_GAIN_Q30);
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx -= dx; cy += dy; ang -= ATAN_TAB[i];
      end else begin
        cx += dx; cy -= dy; ang += ATAN_TAB[i];
      end
    end
    case (w1[31:30])
      2'd0: begin cph = cx;  sph = cy;  end
      2'd1: begin cph = -cy; sph = cx;  end
      2'd2: begin cph = -cx; sph = -cy; end
      default: begin cph = cy; sph = -cx; end
    endcase
    r.x = clamp_q((cph * sz) >>> 30);
    r.y = clamp_q((sph * sz) >>> 30);
    r.z = clamp_q(cz);
    r.word = w2;
    return r;
  endfunction

  task automatic send_item(logic [2:0] act, logic [31:0] cap, bit typed, sample_t val);
    sample_t p;
    s_axis_tdata <= {5'd0, cap, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    p = predict_sample(act, cap);
    sample_q.push_back(typed ? val : p);
    // drop valid only when a gap follows
    if ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sample_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_seed(logic [31:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    gen_state = v;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [2:0] act;
    logic [31:0] cap;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      case ($urandom_range(5))
        0: cap = $urandom();
        1: cap = 32'h4000_0000;
        2: cap = 32'hC000_0000;
        default: cap = 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
      endcase
      if (i == n / 2 && rx_idle < 50) rx_hold = 400;
      send_item(act, cap, 1'b0, '0);
    end
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    sample_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = sample_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: x %h/%h y %h/%h z %h/%h word %h/%h (exp/got)",
                     want.x, got.x, want.y, got.y, want.z, got.z, want.word, got.word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    cycles = 0;
    mismatches = 0;
    rx_hold = 0;
    tx_idle = 22;
    rx_idle = 87;
    gen_state = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the generator is zero, so the first word is the increment
    rw = '{ACT_UNIFORM, 32'h0, 1'b1, '{word: 32'd12345, z: 0, y: 0, x: 0}};
    rows.push_back(rw);
    for (int a = 0; a < 8; a++) rows.push_back('{3'(a), 32'h0, 1'b0, '0});
    rows.push_back('{ACT_CAP, 32'h4000_0000, 1'b0, '0});
    rows.push_back('{ACT_CAP, 32'hC000_0000, 1'b0, '0});
    rows.push_back('{ACT_CAP, 32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{ACT_CAP, 32'h8000_0000, 1'b0, '0});
    rows.push_back('{ACT_CAP, 32'h3FFF_FFFF, 1'b0, '0});
    rows.push_back('{ACT_CAP, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{ACT_SPHERE, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{ACT_HEMI, 32'h8000_0000, 1'b0, '0});
    rows.push_back('{ACT_COSHEMI, 32'h7FFF_FFFF, 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].act, rows[i].cap, rows[i].typed, rows[i].val);
    drain();

    load_seed(32'hFFFF_FFFF);
    random_phase(430);
    drain();

    tx_idle = 87;
    rx_idle = 22;
    load_seed($urandom());
    random_phase(430);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    load_seed(32'h0);
    random_phase(430);
    drain();

    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
